// ----- rtl/bip_pkg.sv -----
// ----------------------------------------------------------------------------
// bip_pkg
// Shared types and constants of the BACnet/IP header parser: parse phase
// codes, result and service class codes, and the packed result record.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bip_pkg;

	// Default width of the payload length and byte offset
	localparam int LENGTH_BITS_DEF = 16;

	// Depth of the result queue
	localparam int RES_DEPTH = 4;

	// Parse phase codes
	localparam logic [4:0] PH_TYPE     = 5'd0;
	localparam logic [4:0] PH_FUNC     = 5'd1;
	localparam logic [4:0] PH_LENHI    = 5'd2;
	localparam logic [4:0] PH_LENLO    = 5'd3;
	localparam logic [4:0] PH_FWD      = 5'd4;
	localparam logic [4:0] PH_NVER     = 5'd5;
	localparam logic [4:0] PH_NCTRL    = 5'd6;
	localparam logic [4:0] PH_DNET     = 5'd7;
	localparam logic [4:0] PH_DLEN     = 5'd8;
	localparam logic [4:0] PH_DADR     = 5'd9;
	localparam logic [4:0] PH_SNET     = 5'd10;
	localparam logic [4:0] PH_SLEN     = 5'd11;
	localparam logic [4:0] PH_SADR     = 5'd12;
	localparam logic [4:0] PH_HOP      = 5'd13;
	localparam logic [4:0] PH_APDU     = 5'd14;
	localparam logic [4:0] PH_CONFSKIP = 5'd15;
	localparam logic [4:0] PH_CONFSVC  = 5'd16;
	localparam logic [4:0] PH_UNCSVC   = 5'd17;
	localparam logic [4:0] PH_CACKINV  = 5'd18;
	localparam logic [4:0] PH_CACKSVC  = 5'd19;
	localparam logic [4:0] PH_TAG      = 5'd20;
	localparam logic [4:0] PH_EXTLEN   = 5'd21;
	localparam logic [4:0] PH_CHARSET  = 5'd22;
	localparam logic [4:0] PH_NAME     = 5'd23;

	// Protocol constants
	localparam logic [7:0] BVLC_TYPE_IP   = 8'h81;
	localparam logic [7:0] BVLC_TYPE_IPV6 = 8'h82;
	localparam logic [7:0] BVLC_FN_MAX    = 8'h0c;
	localparam logic [7:0] BVLC_FN_FWD    = 8'h04;
	localparam logic [7:0] BVLC_FN_ORIG_U = 8'h09;
	localparam logic [7:0] BVLC_FN_ORIG_B = 8'h0a;
	localparam logic [7:0] BVLC_FN_SECURE = 8'h0b;
	localparam logic [7:0] NPDU_VERSION   = 8'h01;
	localparam logic [7:0] CTRL_NSDU      = 8'h80;
	localparam logic [7:0] CTRL_DNET      = 8'h20;
	localparam logic [7:0] CTRL_SNET      = 8'h08;
	localparam logic [7:0] APDU_SEG       = 8'h08;
	localparam logic [3:0] APDU_CONF      = 4'd0;
	localparam logic [3:0] APDU_UNCONF    = 4'd1;
	localparam logic [3:0] APDU_CACK      = 4'd3;
	localparam logic [3:0] APDU_KIND_MAX  = 4'd7;
	localparam logic [7:0] SVC_CONF_LIM   = 8'd30;
	localparam logic [7:0] SVC_UNC_LIM    = 8'd10;
	localparam logic [7:0] SVC_I_AM       = 8'd0;
	localparam logic [7:0] SVC_I_HAVE     = 8'd1;
	localparam logic [7:0] SVC_WHO_HAS    = 8'd7;
	localparam logic [7:0] SVC_RP_ACK     = 8'd12;
	localparam logic [7:0] SVC_RPM_ACK    = 8'd14;
	localparam logic [7:0] TAG_MASK       = 8'hf8;
	localparam logic [7:0] TAG_APP_STR    = 8'h70;
	localparam logic [7:0] TAG_CTX_STR    = 8'h38;
	localparam logic [2:0] TAG_LEN_EXT    = 3'd5;

	// Service class codes
	localparam logic [1:0] SVC_NONE   = 2'd0;
	localparam logic [1:0] SVC_CONF   = 2'd1;
	localparam logic [1:0] SVC_UNCONF = 2'd2;

	// Result kind codes
	localparam logic KIND_NAME    = 1'b0;
	localparam logic KIND_SUMMARY = 1'b1;

	// One result item
	typedef struct packed {
		logic       result_kind;
		logic [7:0] name_char;
		logic       header_valid;
		logic [7:0] bvlc_function;
		logic       function_known;
		logic [3:0] apdu_kind;
		logic       apdu_kind_known;
		logic [7:0] service_choice;
		logic [1:0] service_class;
		logic [7:0] name_length;
		logic       name_found;
		logic       last_of_run;
	} result_t;

endpackage

// ----- rtl/bip_in_if.sv -----
// ----------------------------------------------------------------------------
// bip_in_if
// Input channel: one datagram payload byte per item with length and end mark.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface bip_in_if;
	logic        valid;
	logic        ready;
	logic [7:0]  data_byte;
	logic [15:0] payload_length;
	logic        end_of_packet;

	modport source (output valid, output data_byte, output payload_length,
		output end_of_packet, input ready);
	modport sink (input valid, input data_byte, input payload_length,
		input end_of_packet, output ready);
endinterface

// ----- rtl/bip_out_if.sv -----
// ----------------------------------------------------------------------------
// bip_out_if
// Result channel: object name bytes and end-of-packet summaries.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface bip_out_if;
	logic       valid;
	logic       ready;
	logic       result_kind;
	logic [7:0] name_char;
	logic       header_valid;
	logic [7:0] bvlc_function;
	logic       function_known;
	logic [3:0] apdu_kind;
	logic       apdu_kind_known;
	logic [7:0] service_choice;
	logic [1:0] service_class;
	logic [7:0] name_length;
	logic       name_found;
	logic       last_of_run;

	modport source (output valid, output result_kind, output name_char,
		output header_valid, output bvlc_function, output function_known,
		output apdu_kind, output apdu_kind_known, output service_choice,
		output service_class, output name_length, output name_found,
		output last_of_run, input ready);
	modport sink (input valid, input result_kind, input name_char,
		input header_valid, input bvlc_function, input function_known,
		input apdu_kind, input apdu_kind_known, input service_choice,
		input service_class, input name_length, input name_found,
		input last_of_run, output ready);
endinterface

// ----- rtl/bacnet_ip_header_parser_top.sv -----
// ----------------------------------------------------------------------------
// bacnet_ip_header_parser_top
// Streaming BVLC / NPDU / APDU header parser for BACnet/IP datagrams.
// ----------------------------------------------------------------------------
// Usage:
//   Feed the UDP payload on 'in', one byte per item, with the payload length
//   on every item and end_of_packet set on the last byte. The parser checks
//   the BVLC header, walks the NPDU and APDU headers and, for name-bearing
//   services, emits the CharacterString bytes as name items on 'out'. The
//   last byte of a packet also yields one summary item (last_of_run set).
//   Throughput: one input item per cycle while in.ready is high. Each byte
//   updates the parse state in the cycle it is accepted; its results enter a
//   four-entry result queue and are registered there before they reach 'out'.
//   A byte that both ends a name and ends the packet yields two results; the
//   queue absorbs this, and in.ready drops while it holds more than two
//   results. When the receiver stalls, results wait in the queue and input is
//   taken until the queue is near full. Reset clears the parse state and
//   empties the queue; the block accepts items in the first cycle after
//   reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bacnet_ip_header_parser_top #(
	parameter int LENGTH_BITS = bip_pkg::LENGTH_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	bip_in_if.sink    in,
	bip_out_if.source out
);

	localparam int LB = LENGTH_BITS;
	localparam int QD = bip_pkg::RES_DEPTH;
	localparam int QA = $clog2(QD);
	localparam int QC = $clog2(QD + 1);

	// Parse state
	logic [LB-1:0] off_q;
	logic [4:0]    phase_q;
	logic [7:0]    btype_q;
	logic [7:0]    len_hi_q;
	logic [7:0]    ctrl_q;
	logic [7:0]    skip_q;
	logic [7:0]    left_q;
	logic          stopped_q;
	logic          hv_q;
	logic [7:0]    fn_q;
	logic          fk_q;
	logic [3:0]    ak_q;
	logic          akk_q;
	logic [7:0]    sc_q;
	logic [1:0]    scl_q;
	logic [7:0]    nlen_q;
	logic          nfound_q;

	// Next state
	logic [4:0]    phase_d;
	logic [7:0]    btype_d;
	logic [7:0]    len_hi_d;
	logic [7:0]    ctrl_d;
	logic [7:0]    skip_d;
	logic [7:0]    left_d;
	logic          stopped_d;
	logic          hv_d;
	logic [7:0]    fn_d;
	logic          fk_d;
	logic [3:0]    ak_d;
	logic          akk_d;
	logic [7:0]    sc_d;
	logic [1:0]    scl_d;
	logic [7:0]    nlen_d;
	logic          nfound_d;

	logic [7:0]    b;
	logic [LB-1:0] plen;
	logic [LB-1:0] rem;
	logic [LB-1:0] room;
	logic [15:0]   decl;
	logic [3:0]    kind;
	logic          parse_en;
	logic          emit;
	logic          str_go;
	logic [7:0]    str_len;
	logic          acc;
	logic          pop;

	bip_pkg::result_t name_res;
	bip_pkg::result_t sum_res;
	bip_pkg::result_t e0;
	bip_pkg::result_t head;

	// Result queue
	bip_pkg::result_t q_mem [QD];
	logic [QA-1:0] wr_q;
	logic [QA-1:0] rd_q;
	logic [QC-1:0] cnt_q;
	logic          push0;
	logic          push1;

	assign b    = in.data_byte;
	assign plen = in.payload_length[LB-1:0];
	assign rem  = plen - off_q;
	assign room = rem - LB'(1);
	assign decl = {len_hi_q, b};
	assign kind = b[7:4];
	assign acc  = in.valid && in.ready;
	assign pop  = out.valid && out.ready;
	assign parse_en = !stopped_q && (off_q < plen);

	// Advance the header parse by one byte
	always_comb begin
		phase_d   = phase_q;
		btype_d   = btype_q;
		len_hi_d  = len_hi_q;
		ctrl_d    = ctrl_q;
		skip_d    = skip_q;
		left_d    = left_q;
		stopped_d = stopped_q;
		hv_d      = hv_q;
		fn_d      = fn_q;
		fk_d      = fk_q;
		ak_d      = ak_q;
		akk_d     = akk_q;
		sc_d      = sc_q;
		scl_d     = scl_q;
		nlen_d    = nlen_q;
		nfound_d  = nfound_q;
		emit      = 1'b0;
		str_go    = 1'b0;
		str_len   = 8'd0;
		if (parse_en) begin
			case (phase_q)
				bip_pkg::PH_TYPE: begin
					btype_d = b;
					phase_d = bip_pkg::PH_FUNC;
				end
				bip_pkg::PH_FUNC: begin
					fn_d    = b;
					phase_d = bip_pkg::PH_LENHI;
				end
				bip_pkg::PH_LENHI: begin
					len_hi_d = b;
					phase_d  = bip_pkg::PH_LENLO;
				end
				bip_pkg::PH_LENLO: begin
					if (decl < 16'd4 || decl > 16'(plen) ||
					    (btype_q != bip_pkg::BVLC_TYPE_IP &&
					     btype_q != bip_pkg::BVLC_TYPE_IPV6)) begin
						fn_d      = 8'd0;
						stopped_d = 1'b1;
					end else begin
						hv_d = 1'b1;
						fk_d = (fn_q <= bip_pkg::BVLC_FN_MAX);
						if (fn_q == bip_pkg::BVLC_FN_FWD) begin
							skip_d  = (btype_q == bip_pkg::BVLC_TYPE_IP) ? 8'd6 : 8'd18;
							phase_d = bip_pkg::PH_FWD;
						end else if (fn_q == bip_pkg::BVLC_FN_ORIG_U ||
						             fn_q == bip_pkg::BVLC_FN_ORIG_B ||
						             fn_q == bip_pkg::BVLC_FN_SECURE) begin
							phase_d = bip_pkg::PH_NVER;
						end else begin
							stopped_d = 1'b1;
						end
					end
				end
				bip_pkg::PH_FWD: begin
					skip_d = skip_q - 8'd1;
					if (skip_q == 8'd1) phase_d = bip_pkg::PH_NVER;
				end
				bip_pkg::PH_NVER: begin
					if (b != bip_pkg::NPDU_VERSION) stopped_d = 1'b1;
					else phase_d = bip_pkg::PH_NCTRL;
				end
				bip_pkg::PH_NCTRL: begin
					ctrl_d = b;
					if ((b & bip_pkg::CTRL_NSDU) != 8'd0) begin
						stopped_d = 1'b1;
					end else if ((b & bip_pkg::CTRL_DNET) != 8'd0) begin
						phase_d = bip_pkg::PH_DNET;
						skip_d  = 8'd2;
					end else if ((b & bip_pkg::CTRL_SNET) != 8'd0) begin
						phase_d = bip_pkg::PH_SNET;
						skip_d  = 8'd2;
					end else begin
						phase_d = bip_pkg::PH_APDU;
					end
				end
				bip_pkg::PH_DNET: begin
					skip_d = skip_q - 8'd1;
					if (skip_q == 8'd1) phase_d = bip_pkg::PH_DLEN;
				end
				bip_pkg::PH_DLEN, bip_pkg::PH_DADR: begin
					if (phase_q == bip_pkg::PH_DLEN) skip_d = b;
					else skip_d = skip_q - 8'd1;
					if (phase_q == bip_pkg::PH_DLEN && b != 8'd0) begin
						phase_d = bip_pkg::PH_DADR;
					end else if (phase_q == bip_pkg::PH_DADR && skip_q != 8'd1) begin
						phase_d = bip_pkg::PH_DADR;
					end else if ((ctrl_q & bip_pkg::CTRL_SNET) != 8'd0) begin
						phase_d = bip_pkg::PH_SNET;
						skip_d  = 8'd2;
					end else if ((ctrl_q & bip_pkg::CTRL_DNET) != 8'd0) begin
						phase_d = bip_pkg::PH_HOP;
					end else begin
						phase_d = bip_pkg::PH_APDU;
					end
				end
				bip_pkg::PH_SNET: begin
					skip_d = skip_q - 8'd1;
					if (skip_q == 8'd1) phase_d = bip_pkg::PH_SLEN;
				end
				bip_pkg::PH_SLEN, bip_pkg::PH_SADR: begin
					if (phase_q == bip_pkg::PH_SLEN) skip_d = b;
					else skip_d = skip_q - 8'd1;
					if (phase_q == bip_pkg::PH_SLEN && b != 8'd0) begin
						phase_d = bip_pkg::PH_SADR;
					end else if (phase_q == bip_pkg::PH_SADR && skip_q != 8'd1) begin
						phase_d = bip_pkg::PH_SADR;
					end else if ((ctrl_q & bip_pkg::CTRL_DNET) != 8'd0) begin
						phase_d = bip_pkg::PH_HOP;
					end else begin
						phase_d = bip_pkg::PH_APDU;
					end
				end
				bip_pkg::PH_HOP: phase_d = bip_pkg::PH_APDU;
				bip_pkg::PH_APDU: begin
					ak_d  = kind;
					akk_d = (kind <= bip_pkg::APDU_KIND_MAX);
					if (kind == bip_pkg::APDU_CONF) begin
						skip_d  = ((b & bip_pkg::APDU_SEG) != 8'd0) ? 8'd3 : 8'd2;
						phase_d = bip_pkg::PH_CONFSKIP;
					end else if (kind == bip_pkg::APDU_UNCONF) begin
						phase_d = bip_pkg::PH_UNCSVC;
					end else if (kind == bip_pkg::APDU_CACK) begin
						phase_d = bip_pkg::PH_CACKINV;
					end else begin
						stopped_d = 1'b1;
					end
				end
				bip_pkg::PH_CONFSKIP: begin
					skip_d = skip_q - 8'd1;
					if (skip_q == 8'd1) phase_d = bip_pkg::PH_CONFSVC;
				end
				bip_pkg::PH_CONFSVC: begin
					sc_d      = b;
					scl_d     = (b < bip_pkg::SVC_CONF_LIM) ? bip_pkg::SVC_CONF : bip_pkg::SVC_NONE;
					stopped_d = 1'b1;
				end
				bip_pkg::PH_UNCSVC: begin
					sc_d  = b;
					scl_d = (b < bip_pkg::SVC_UNC_LIM) ? bip_pkg::SVC_UNCONF : bip_pkg::SVC_NONE;
					if (b == bip_pkg::SVC_I_AM || b == bip_pkg::SVC_I_HAVE ||
					    b == bip_pkg::SVC_WHO_HAS) begin
						phase_d = bip_pkg::PH_TAG;
					end else begin
						stopped_d = 1'b1;
					end
				end
				bip_pkg::PH_CACKINV: phase_d = bip_pkg::PH_CACKSVC;
				bip_pkg::PH_CACKSVC: begin
					if (b == bip_pkg::SVC_RP_ACK || b == bip_pkg::SVC_RPM_ACK) begin
						phase_d = bip_pkg::PH_TAG;
					end else begin
						stopped_d = 1'b1;
					end
				end
				bip_pkg::PH_TAG: begin
					if (rem < LB'(3)) begin
						stopped_d = 1'b1;
					end else if ((b & bip_pkg::TAG_MASK) == bip_pkg::TAG_APP_STR ||
					             (b & bip_pkg::TAG_MASK) == bip_pkg::TAG_CTX_STR) begin
						if (b[2:0] == bip_pkg::TAG_LEN_EXT) begin
							phase_d = bip_pkg::PH_EXTLEN;
						end else if (b[2:0] < bip_pkg::TAG_LEN_EXT) begin
							str_go  = 1'b1;
							str_len = {5'd0, b[2:0]};
						end
					end
				end
				bip_pkg::PH_EXTLEN: begin
					str_go  = 1'b1;
					str_len = b;
				end
				bip_pkg::PH_CHARSET: begin
					if (left_q == 8'd0) stopped_d = 1'b1;
					else phase_d = bip_pkg::PH_NAME;
				end
				bip_pkg::PH_NAME: begin
					left_d = left_q - 8'd1;
					if (left_q == 8'd1) stopped_d = 1'b1;
					emit = 1'b1;
				end
				default: stopped_d = 1'b1;
			endcase
		end

		// Open a string, charset byte included in its length
		if (str_go) begin
			if (str_len == 8'd0 || room < LB'(str_len)) begin
				stopped_d = 1'b1;
			end else begin
				left_d  = str_len - 8'd1;
				phase_d = bip_pkg::PH_CHARSET;
			end
		end

		// Count emitted name bytes
		if (emit) begin
			if (nlen_q != 8'hff) nlen_d = nlen_q + 8'd1;
			nfound_d = 1'b1;
		end
	end

	// Build the result items
	always_comb begin
		name_res             = '0;
		name_res.result_kind = bip_pkg::KIND_NAME;
		name_res.name_char   = b;

		sum_res                 = '0;
		sum_res.result_kind     = bip_pkg::KIND_SUMMARY;
		sum_res.header_valid    = hv_d;
		sum_res.bvlc_function   = fn_d;
		sum_res.function_known  = fk_d;
		sum_res.apdu_kind       = ak_d;
		sum_res.apdu_kind_known = akk_d;
		sum_res.service_choice  = sc_d;
		sum_res.service_class   = scl_d;
		sum_res.name_length     = nlen_d;
		sum_res.name_found      = nfound_d;
		sum_res.last_of_run     = 1'b1;

		e0 = emit ? name_res : sum_res;
	end

	// Hold the parse state; return to reset after each summary
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_q     <= '0;
			phase_q   <= bip_pkg::PH_TYPE;
			btype_q   <= '0;
			len_hi_q  <= '0;
			ctrl_q    <= '0;
			skip_q    <= '0;
			left_q    <= '0;
			stopped_q <= 1'b0;
			hv_q      <= 1'b0;
			fn_q      <= '0;
			fk_q      <= 1'b0;
			ak_q      <= '0;
			akk_q     <= 1'b0;
			sc_q      <= '0;
			scl_q     <= bip_pkg::SVC_NONE;
			nlen_q    <= '0;
			nfound_q  <= 1'b0;
		end else if (acc) begin
			if (in.end_of_packet) begin
				off_q     <= '0;
				phase_q   <= bip_pkg::PH_TYPE;
				btype_q   <= '0;
				len_hi_q  <= '0;
				ctrl_q    <= '0;
				skip_q    <= '0;
				left_q    <= '0;
				stopped_q <= 1'b0;
				hv_q      <= 1'b0;
				fn_q      <= '0;
				fk_q      <= 1'b0;
				ak_q      <= '0;
				akk_q     <= 1'b0;
				sc_q      <= '0;
				scl_q     <= bip_pkg::SVC_NONE;
				nlen_q    <= '0;
				nfound_q  <= 1'b0;
			end else begin
				if (off_q != {LB{1'b1}}) off_q <= off_q + LB'(1);
				phase_q   <= phase_d;
				btype_q   <= btype_d;
				len_hi_q  <= len_hi_d;
				ctrl_q    <= ctrl_d;
				skip_q    <= skip_d;
				left_q    <= left_d;
				stopped_q <= stopped_d;
				hv_q      <= hv_d;
				fn_q      <= fn_d;
				fk_q      <= fk_d;
				ak_q      <= ak_d;
				akk_q     <= akk_d;
				sc_q      <= sc_d;
				scl_q     <= scl_d;
				nlen_q    <= nlen_d;
				nfound_q  <= nfound_d;
			end
		end
	end

	// Push up to two results per item
	assign push0 = acc && (emit || in.end_of_packet);
	assign push1 = acc && emit && in.end_of_packet;

	always_ff @(posedge clk) begin
		if (push0) q_mem[wr_q] <= e0;
		if (push1) q_mem[wr_q + QA'(1)] <= sum_res;
	end

	// Track queue pointers and fill
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + QA'(push0) + QA'(push1);
			if (pop) rd_q <= rd_q + QA'(1);
			cnt_q <= cnt_q + QC'(push0) + QC'(push1) - QC'(pop);
		end
	end

	// Drive the channels
	assign in.ready = (cnt_q <= QC'(QD - 2));
	assign head     = q_mem[rd_q];

	assign out.valid           = (cnt_q != '0);
	assign out.result_kind     = head.result_kind;
	assign out.name_char       = head.name_char;
	assign out.header_valid    = head.header_valid;
	assign out.bvlc_function   = head.bvlc_function;
	assign out.function_known  = head.function_known;
	assign out.apdu_kind       = head.apdu_kind;
	assign out.apdu_kind_known = head.apdu_kind_known;
	assign out.service_choice  = head.service_choice;
	assign out.service_class   = head.service_class;
	assign out.name_length     = head.name_length;
	assign out.name_found      = head.name_found;
	assign out.last_of_run     = head.last_of_run;

`ifndef SYNTHESIS
	// Queue fill never exceeds its depth
	a_fill: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= QC'(QD))
		else $error("result queue overfilled");

	// A packet end always leaves a result waiting
	a_eop_out: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && in.end_of_packet) |=> out.valid)
		else $error("no result after end of packet");

	// A packet end returns the parser to its start
	a_eop_reset: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && in.end_of_packet) |=>
		(phase_q == bip_pkg::PH_TYPE && !stopped_q && off_q == '0))
		else $error("parse state not cleared after packet end");
`endif

endmodule
